// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ibvp_pkg.sv -----
package ibvp_pkg;

  localparam int BLOCK_COUNT_DEF = 63;
  localparam int IDX_W = 6;
  localparam int ICNT_W = 12;
  localparam int CNT_W = 48;
  localparam int INTV_W = 32;
  localparam logic [CNT_W-1:0] INTERVAL_LENGTH_RST = 48'd100000000;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_TRAILER = 1'b1;

  typedef struct packed {
    logic accept_en;
    logic rd_item;
    logic update;
    logic scan_start;
    logic scan_next;
    logic entry_load;
    logic trailer_load;
  } ibvp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_finish;
    logic close;
    logic hit;
    logic scan_last;
    logic out_free;
  } ibvp_stat_t;

endpackage

// ----- rtl/ibvp_in_if.sv -----
interface ibvp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [ibvp_pkg::IDX_W-1:0]     block_index;
  logic [ibvp_pkg::ICNT_W-1:0]    inst_count;
  logic [ibvp_pkg::ICNT_W-1:0]    waypoint_count;

  modport source (output valid, command, block_index, inst_count, waypoint_count,
                  input ready);
  modport sink (input valid, command, block_index, inst_count, waypoint_count,
                output ready);
endinterface

// ----- rtl/ibvp_out_if.sv -----
interface ibvp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ibvp_pkg::IDX_W-1:0]    block_id;
  logic [ibvp_pkg::CNT_W-1:0]    hit_count;
  logic [ibvp_pkg::INTV_W-1:0]   interval_number;
  logic [ibvp_pkg::CNT_W-1:0]    previous_instructions;
  logic [ibvp_pkg::CNT_W-1:0]    total_instructions;
  logic [ibvp_pkg::CNT_W-1:0]    previous_waypoints;
  logic [ibvp_pkg::CNT_W-1:0]    total_waypoints;
  logic                          last;

  modport source (output valid, kind, block_id, hit_count, interval_number,
                  previous_instructions, total_instructions, previous_waypoints,
                  total_waypoints, last, input ready);
  modport sink (input valid, kind, block_id, hit_count, interval_number,
                previous_instructions, total_instructions, previous_waypoints,
                total_waypoints, last, output ready);
endinterface

// ----- rtl/ibvp_datapath.sv -----
module ibvp_datapath #(
  parameter int BLOCK_COUNT = ibvp_pkg::BLOCK_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ibvp_in_if.sink                     in_if,
  ibvp_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [ibvp_pkg::CNT_W-1:0]  cfg_data,
  input  ibvp_pkg::ibvp_cmd_t         cmd,
  output ibvp_pkg::ibvp_stat_t        stat
);

  localparam int IW = ibvp_pkg::IDX_W;
  localparam int CW = ibvp_pkg::CNT_W;
  localparam int NW = ibvp_pkg::INTV_W;
  localparam int AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  logic [CW-1:0] hit_mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] valid_r;

  logic                         cmd_r;
  logic [IW-1:0]                idx_r;
  logic [ibvp_pkg::ICNT_W-1:0]  inst_r;
  logic [ibvp_pkg::ICNT_W-1:0]  wps_r;

  logic [AW-1:0] scan_r;
  logic [CW-1:0] rd_data_r;
  logic          rd_vld_r;

  logic [CW-1:0] len_r;
  logic [CW-1:0] pend_r;
  logic [CW-1:0] inst_tot_r;
  logic [CW-1:0] inst_prev_r;
  logic [CW-1:0] wp_tot_r;
  logic [CW-1:0] wp_prev_r;
  logic [NW-1:0] intv_r;

  logic          out_valid_r;
  logic          kind_r;
  logic [IW-1:0] block_id_r;
  logic [CW-1:0] hit_r;
  logic [NW-1:0] onum_r;
  logic [CW-1:0] oprev_i_r;
  logic [CW-1:0] otot_i_r;
  logic [CW-1:0] oprev_w_r;
  logic [CW-1:0] otot_w_r;
  logic          last_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] item_addr;
  logic          in_range;
  logic [CW-1:0] hit_nxt;
  logic          out_load;
  logic          in_fire;

  assign in_if.ready = cmd.accept_en;
  assign in_fire   = in_if.valid & in_if.ready;
  assign item_addr = idx_r[AW-1:0];
  assign in_range  = idx_r < IW'(BLOCK_COUNT);
  assign rd_addr   = cmd.rd_item ? item_addr : scan_r;
  assign hit_nxt   = (rd_vld_r ? rd_data_r : '0) + CW'(inst_r);
  assign out_load  = cmd.entry_load | cmd.trailer_load;

  assign stat.in_valid  = in_if.valid;
  assign stat.in_finish = in_if.command == ibvp_pkg::CMD_FINISH;
  assign stat.close     = pend_r >= len_r;
  assign stat.hit       = rd_vld_r & (rd_data_r != '0);
  assign stat.scan_last = scan_r == AW'(BLOCK_COUNT - 1);
  assign stat.out_free  = ~out_valid_r | out_if.ready;

  // hit table
  always_ff @(posedge clk) begin
    rd_data_r <= hit_mem[rd_addr];
    if (cmd.update && in_range) begin
      hit_mem[item_addr] <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (cmd.update && in_range) begin
        valid_r[item_addr] <= 1'b1;
      end
      if (cmd.entry_load) begin
        valid_r[scan_r] <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_if.command;
      idx_r  <= in_if.block_index;
      inst_r <= in_if.inst_count;
      wps_r  <= in_if.waypoint_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (cmd.scan_start) begin
      scan_r <= '0;
    end else if (cmd.scan_next) begin
      scan_r <= scan_r + AW'(1);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= ibvp_pkg::INTERVAL_LENGTH_RST;
      pend_r      <= '0;
      inst_tot_r  <= '0;
      inst_prev_r <= '0;
      wp_tot_r    <= '0;
      wp_prev_r   <= '0;
      intv_r      <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_data;
      end
      if (cmd.update && cmd_r == ibvp_pkg::CMD_EVENT) begin
        pend_r   <= pend_r + CW'(inst_r);
        wp_tot_r <= wp_tot_r + CW'(wps_r);
      end
      if (cmd.trailer_load) begin
        wp_prev_r   <= wp_tot_r;
        inst_prev_r <= inst_tot_r;
        inst_tot_r  <= inst_tot_r + pend_r;
        pend_r      <= '0;
        intv_r      <= intv_r + NW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r     <= cmd.trailer_load ? ibvp_pkg::KIND_TRAILER : ibvp_pkg::KIND_ENTRY;
      block_id_r <= cmd.trailer_load ? '0 : IW'(scan_r) + IW'(1);
      hit_r      <= cmd.trailer_load ? '0 : rd_data_r;
      last_r     <= cmd.trailer_load;
      onum_r     <= intv_r;
      oprev_i_r  <= inst_prev_r;
      otot_i_r   <= inst_tot_r;
      oprev_w_r  <= wp_prev_r;
      otot_w_r   <= wp_tot_r;
    end
  end

  assign out_if.valid                 = out_valid_r;
  assign out_if.kind                  = kind_r;
  assign out_if.block_id              = block_id_r;
  assign out_if.hit_count             = hit_r;
  assign out_if.interval_number       = onum_r;
  assign out_if.previous_instructions = oprev_i_r;
  assign out_if.total_instructions    = otot_i_r;
  assign out_if.previous_waypoints    = oprev_w_r;
  assign out_if.total_waypoints       = otot_w_r;
  assign out_if.last                  = last_r;

endmodule

// ----- rtl/ibvp_ctrl.sv -----
module ibvp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ibvp_pkg::ibvp_stat_t  stat,
  output ibvp_pkg::ibvp_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_SRD   = 7'b0010000,
    S_SCHK  = 7'b0100000,
    S_TRAIL = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_finish) begin
            cmd.scan_start = 1'b1;
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_item = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.close) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (!stat.hit || stat.out_free) begin
          cmd.entry_load = stat.hit;
          if (stat.scan_last) begin
            state_nxt = S_TRAIL;
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_TRAIL: begin
        if (stat.out_free) begin
          cmd.trailer_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/interval_block_vector_profiler.sv -----
// Interval block-vector profiler.
// in_if: block events and finish commands, one transfer per valid/ready pair.
// out_if: per-block hit entries in ascending id order, then one trailer with
//   last set; every result of a dump carries the same interval totals.
// cfg_we/cfg_data: write the interval length; write only while idle.
// An event goes through accept, table read, table update and interval check in
// turn; in_if.ready is high only in the accept step. The hit table is a one-port
// read, one-port write memory with a registered read, hence the separate read step.
// A dump (interval length reached or finish command) walks the table entry by
// entry, a read state then a check state for each, and emits each nonzero entry,
// then the trailer. No new item is accepted until the trailer is loaded, and
// each empty entry ahead of the first result delays it by one more walk step.
// A finished result sits in an output register, so a stalled receiver only
// holds the walk at the next nonzero entry or the trailer; nothing is dropped.
// Reset is synchronous: counters clear, the interval length returns to
// 100000000 and per-entry valid bits empty the hit table at once, with no
// clearing pass; the block is ready to accept items as soon as reset is released.
module interval_block_vector_profiler #(
  parameter int BLOCK_COUNT = ibvp_pkg::BLOCK_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ibvp_in_if.sink                     in_if,
  ibvp_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [ibvp_pkg::CNT_W-1:0]  cfg_data
);

  ibvp_pkg::ibvp_cmd_t  cmd;
  ibvp_pkg::ibvp_stat_t stat;

  ibvp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  ibvp_datapath #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- rtl/ibvp_checker.sv -----
`include "assert_macros.svh"

module ibvp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic                        out_last,
  input logic [ibvp_pkg::IDX_W-1:0]  out_block_id,
  input logic [ibvp_pkg::CNT_W-1:0]  out_hit_count
);

  `CHK_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid right after reset")
  `CHK_ON(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hit_count), "stalled result changed")
  `CHK_ON(a_trailer, out_valid && out_last |-> out_kind && out_block_id == '0 && out_hit_count == '0, "malformed trailer")
  `CHK_ON(a_entry, out_valid && !out_last |-> !out_kind && out_block_id != '0 && out_hit_count != '0, "malformed hit entry")
  `CHK_ON(a_finish_busy, in_valid && in_ready && in_command |=> !in_ready, "input taken during dump")

endmodule

bind interval_block_vector_profiler ibvp_checker u_ibvp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_command    (in_if.command),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_kind      (out_if.kind),
  .out_last      (out_if.last),
  .out_block_id  (out_if.block_id),
  .out_hit_count (out_if.hit_count)
);
